// ----- hw/rtl/ecep_pkg.sv -----
`timescale 1ns / 1ps

package ecep_pkg;

   localparam int CNT_W  = 16;
   localparam int LIFE_W = 16;
   localparam int EXP_W  = 32;
   localparam int TOT_W  = 32;

   // one stored batch
   typedef struct packed {
      logic [EXP_W-1:0] expiry;
      logic [CNT_W-1:0] remaining;
   } slot_type;

   // operands of the shared compare unit
   typedef struct packed {
      logic [EXP_W-1:0] expiry;
      logic [CNT_W-1:0] remaining;
      logic [EXP_W-1:0] now;
      logic [EXP_W-1:0] best_exp;
      logic             found;
   } cmp_in_type;

   // compare unit flags
   typedef struct packed {
      logic live;
      logic earlier;
      logic same;
   } cmp_res_type;

endpackage

// ----- hw/rtl/ecep_if.sv -----
`timescale 1ns / 1ps

interface ecep_req_if import ecep_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CNT_W-1:0]  add_count;
   logic [LIFE_W-1:0] add_lifetime;

   modport source (output valid, output add_count, output add_lifetime, input ready);
   modport sink (input valid, input add_count, input add_lifetime, output ready);
endinterface

interface ecep_rsp_if import ecep_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             consumed;
   logic [TOT_W-1:0] total_consumed;
   logic             pool_empty;
   logic             batch_dropped;

   modport source (output valid, output consumed, output total_consumed,
                   output pool_empty, output batch_dropped, input ready);
   modport sink (input valid, input consumed, input total_consumed,
                 input pool_empty, input batch_dropped, output ready);
endinterface

// ----- hw/rtl/ecep_mem.sv -----
`timescale 1ns / 1ps

module ecep_mem import ecep_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  slot_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output slot_type      rd_data
);

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ecep_cmp.sv -----
`timescale 1ns / 1ps

module ecep_cmp import ecep_pkg::*; (
   input  cmp_in_type  cmp_in,
   output cmp_res_type cmp_res
);

   // live: units left and deadline still ahead
   assign cmp_res.live    = (cmp_in.remaining != '0) && (cmp_in.expiry > cmp_in.now);
   assign cmp_res.earlier = !cmp_in.found || (cmp_in.expiry < cmp_in.best_exp);
   assign cmp_res.same    = cmp_in.found && (cmp_in.expiry == cmp_in.best_exp);

endmodule

// ----- hw/rtl/expiring_credit_edf_pool_core.sv -----
`timescale 1ns / 1ps

// channel   | dir | payload                                           | transaction
// req_chan  | in  | add_count, add_lifetime                           | one tick
// rsp_chan  | out | consumed, total_consumed, pool_empty, batch_dropped | one result per tick
//
// a tick scans the slots below hwm, then inserts, consumes and posts its result; hwm
// being the number of slots ever used (at most POOL_DEPTH); the single read port of the
// slot memory walks them one per cycle through the shared compare unit
// reset is synchronous and clears control state and the high-water mark, not the memory
// a finished result waits in the output register while the next tick is accepted;
// the sequencer only stalls when a second result is ready before the first is taken

module expiring_credit_edf_pool_core import ecep_pkg::*; #(
   parameter int POOL_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   ecep_req_if.sink   req_chan,
   ecep_rsp_if.source rsp_chan
);

   localparam int IW = $clog2(POOL_DEPTH);
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_INSERT,
      S_CONSUME,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // slot bookkeeping
   logic [CW-1:0]    hwm_ff, hwm_in;          // slots at or above never written
   logic [CW-1:0]    live_cnt_ff, live_cnt_in;
   logic [EXP_W-1:0] tick_ff, tick_in;
   logic [TOT_W-1:0] total_ff, total_in;

   // current tick
   logic [CNT_W-1:0] count_ff, count_in;
   logic [EXP_W-1:0] exp_ff, exp_in;

   // scan pipeline
   logic [CW-1:0] issue_ff, issue_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;

   // scan results
   logic             found_ff, found_in;
   logic [IW-1:0]    best_idx_ff, best_idx_in;
   logic [EXP_W-1:0] best_exp_ff, best_exp_in;
   logic [CNT_W-1:0] best_rem_ff, best_rem_in;
   logic             free_found_ff, free_found_in;
   logic [IW-1:0]    free_idx_ff, free_idx_in;
   logic             took_ff, took_in;
   logic             dropped_ff, dropped_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_consumed_ff, rsp_consumed_in;
   logic [TOT_W-1:0] rsp_total_ff, rsp_total_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_dropped_ff, rsp_dropped_in;

   // memory and compare unit hookup
   logic          mem_we, mem_re;
   logic [IW-1:0] mem_waddr;
   slot_type      mem_wdata, mem_rdata;
   cmp_in_type    cmp_in;
   cmp_res_type   cmp_res;

   logic [EXP_W:0] exp_sum;
   logic [IW-1:0]  slot_idx;
   logic           have_slot;

   ecep_mem #(
      .DEPTH (POOL_DEPTH),
      .AW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (issue_ff[IW-1:0]),
      .rd_data (mem_rdata)
   );

   ecep_cmp u_cmp (
      .cmp_in  (cmp_in),
      .cmp_res (cmp_res)
   );

   // compare unit sees the scanned slot, or the arriving batch while inserting
   always_comb begin
      cmp_in.now      = tick_ff;
      cmp_in.best_exp = best_exp_ff;
      cmp_in.found    = found_ff;
      if (state_ff == S_INSERT) begin
         cmp_in.expiry    = exp_ff;
         cmp_in.remaining = count_ff;
      end else begin
         cmp_in.expiry    = mem_rdata.expiry;
         cmp_in.remaining = mem_rdata.remaining;
      end
   end

   // expiry of the arriving batch, saturating at the top of the range
   assign exp_sum = {1'b0, tick_ff} + {{(EXP_W + 1 - LIFE_W){1'b0}}, req_chan.add_lifetime};

   // lowest free slot, else the first never used one
   assign slot_idx  = free_found_ff ? free_idx_ff : hwm_ff[IW-1:0];
   assign have_slot = free_found_ff || (hwm_ff != DEPTH_C);

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      hwm_in          = hwm_ff;
      live_cnt_in     = live_cnt_ff;
      tick_in         = tick_ff;
      total_in        = total_ff;
      count_in        = count_ff;
      exp_in          = exp_ff;
      issue_in        = issue_ff;
      rd_vld_in       = rd_vld_ff;
      rd_idx_in       = rd_idx_ff;
      found_in        = found_ff;
      best_idx_in     = best_idx_ff;
      best_exp_in     = best_exp_ff;
      best_rem_in     = best_rem_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      took_in         = took_ff;
      dropped_in      = dropped_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_consumed_in = rsp_consumed_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_empty_in    = rsp_empty_ff;
      rsp_dropped_in  = rsp_dropped_ff;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      mem_waddr       = slot_idx;
      mem_wdata       = '{expiry: exp_ff, remaining: count_ff};

      // result taken downstream
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               count_in      = req_chan.add_count;
               exp_in        = exp_sum[EXP_W] ? '1 : exp_sum[EXP_W-1:0];
               issue_in      = '0;
               rd_vld_in     = 1'b0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               live_cnt_in   = '0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one read per cycle; the memory registers its read data
            rd_vld_in = 1'b0;
            if (issue_ff != hwm_ff) begin
               mem_re    = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IW-1:0];
               issue_in  = issue_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (cmp_res.live) begin
                  live_cnt_in = live_cnt_ff + 1'b1;
                  // strict compare keeps the lowest index on equal expiries
                  if (cmp_res.earlier) begin
                     found_in    = 1'b1;
                     best_idx_in = rd_idx_ff;
                     best_exp_in = mem_rdata.expiry;
                     best_rem_in = mem_rdata.remaining;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
            end
            if ((issue_ff == hwm_ff) && !rd_vld_ff) begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            dropped_in = 1'b0;
            // nonzero count and expiry still ahead
            if (cmp_res.live) begin
               if (have_slot) begin
                  mem_we      = 1'b1;
                  live_cnt_in = live_cnt_ff + 1'b1;
                  if (!free_found_ff) begin
                     hwm_in = hwm_ff + 1'b1;
                  end
                  if (cmp_res.earlier || (cmp_res.same && (slot_idx < best_idx_ff))) begin
                     found_in    = 1'b1;
                     best_idx_in = slot_idx;
                     best_exp_in = exp_ff;
                     best_rem_in = count_ff;
                  end
               end else begin
                  dropped_in = 1'b1;
               end
            end
            state_in = S_CONSUME;
         end
         S_CONSUME: begin
            took_in = found_ff;
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = best_idx_ff;
               mem_wdata = '{expiry: best_exp_ff, remaining: best_rem_ff - 1'b1};
               // last unit retires the batch
               if (best_rem_ff == CNT_W'(1)) begin
                  live_cnt_in = live_cnt_ff - 1'b1;
               end
               if (total_ff != '1) begin
                  total_in = total_ff + 1'b1;
               end
            end
            if (tick_ff != '1) begin
               tick_in = tick_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_consumed_in = took_ff;
               rsp_total_in    = total_ff;
               rsp_empty_in    = (live_cnt_ff == '0);
               rsp_dropped_in  = dropped_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hwm_ff       <= '0;
         live_cnt_ff  <= '0;
         tick_ff      <= '0;
         total_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hwm_ff       <= hwm_in;
         live_cnt_ff  <= live_cnt_in;
         tick_ff      <= tick_in;
         total_ff     <= total_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff        <= count_in;
      exp_ff          <= exp_in;
      issue_ff        <= issue_in;
      rd_idx_ff       <= rd_idx_in;
      found_ff        <= found_in;
      best_idx_ff     <= best_idx_in;
      best_exp_ff     <= best_exp_in;
      best_rem_ff     <= best_rem_in;
      free_found_ff   <= free_found_in;
      free_idx_ff     <= free_idx_in;
      took_ff         <= took_in;
      dropped_ff      <= dropped_in;
      rsp_consumed_ff <= rsp_consumed_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_empty_ff    <= rsp_empty_in;
      rsp_dropped_ff  <= rsp_dropped_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.consumed       = rsp_consumed_ff;
   assign rsp_chan.total_consumed = rsp_total_ff;
   assign rsp_chan.pool_empty     = rsp_empty_ff;
   assign rsp_chan.batch_dropped  = rsp_dropped_ff;

   // high-water mark never passes the store depth
   a_hwm_bound: assert property (@(posedge clock) disable iff (reset)
      hwm_ff <= DEPTH_C)
      else $error("high-water mark beyond pool depth");

   // live batch count never exceeds the high-water mark between ticks
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (live_cnt_ff <= hwm_ff))
      else $error("live count above high-water mark");

   // a dropped batch means every slot has been used
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.batch_dropped) |-> (hwm_ff == DEPTH_C))
      else $error("batch dropped while slots remain");

   // nothing consumed means nothing was live
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.consumed) |-> rsp_chan.pool_empty)
      else $error("pool not empty although nothing consumed");

endmodule
